// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/lcdnw_pkg.sv =====
// ---------------------------------------------------------------------------
// LCD nibble writer package
// Transaction types, operation codes and byte constants for the LCD writer.
// ---------------------------------------------------------------------------
package lcdnw_pkg;

    localparam logic [2:0] CMD_BYTE   = 3'd0;
    localparam logic [2:0] CMD_CHAR   = 3'd1;
    localparam logic [2:0] CMD_CURSOR = 3'd2;
    localparam logic [2:0] CMD_NUMBER = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_INIT   = 3'd5;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    localparam logic [7:0] INIT_SEQ [4] = '{8'h02, 8'h28, 8'h0C, 8'h06};
    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h90, 8'hD0};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  byte_value;
        logic [3:0]  column;
        logic [1:0]  row;
        logic [31:0] number;
    } t_lcd_in;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last_of_run;
    } t_lcd_out;

    // Status of the decimal converter as seen by the sequencer.
    typedef struct packed {
        logic       ready;
        logic       last;
        logic [3:0] digit;
    } t_bcd_status;

endpackage

// ===== rtl/char_lcd_nibble_writer_core.sv =====
// ---------------------------------------------------------------------------
// Character LCD nibble writer
// Turns LCD operations into a run of 4-bit bus transfers, high nibble first.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// item      in         start & !busy         i_item   (lcdnw_pkg::t_lcd_in)
// nibble    out        o_strobe, one cycle   o_result (lcdnw_pkg::t_lcd_out)
//
// A byte operation holds busy while it sends two nibbles per byte, one nibble per cycle.
// A number holds busy through a bit-serial conversion of min(NUMBER_BITS,32) bits,
// a skip of leading zero digits, then two nibbles per digit.
// Every nibble is registered and strobed in the cycle after it is formed, so the
// last one is on the port in the same cycle that busy falls, and the next
// transaction can be accepted at the edge that ends that cycle.
// Reset is synchronous and returns the block to idle; the receiver cannot stall.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_writer_core #(
    parameter int ROW_COLUMNS = 16,
    parameter int NUMBER_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  lcdnw_pkg::t_lcd_in  i_item,
    output logic                busy,
    output logic                o_strobe,
    output lcdnw_pkg::t_lcd_out o_result
);
    import lcdnw_pkg::*;

    localparam int CONV_BITS = (NUMBER_BITS < 32) ? NUMBER_BITS : 32;
    localparam int NDIG      = (CONV_BITS * 30103) / 100000 + 1;
    localparam int IDX_W     = $clog2(ROW_COLUMNS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_BYTES  = 2'd1;
    localparam logic [1:0] S_DIGITS = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [7:0]       r_byte, n_byte;
    logic [3:0]       r_col, n_col;
    logic [1:0]       r_row, n_row;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_half, n_half;
    logic             r_strobe, n_strobe;
    t_lcd_out         r_res, n_res;

    logic             w_accept;
    logic             w_bcd_start;
    logic             w_bcd_next;
    t_bcd_status      w_bcd;
    logic             w_rs;
    logic [7:0]       w_cur;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Byte and register select for the current step of a byte operation.
    always_comb begin
        w_rs       = 1'b0;
        w_cur      = r_byte;
        w_last_idx = '0;
        unique case (r_op)
            CMD_CHAR:   w_rs = 1'b1;
            CMD_CURSOR: w_cur = ROW_BASE[r_row] | {4'd0, r_col};
            CMD_CLEAR: begin
                w_last_idx = IDX_W'(ROW_COLUMNS);
                if (r_idx != '0) begin
                    w_rs  = 1'b1;
                    w_cur = SPACE_CHAR;
                end else begin
                    w_cur = ROW_BASE[r_row];
                end
            end
            CMD_INIT: begin
                w_last_idx = IDX_W'(3);
                w_cur      = INIT_SEQ[r_idx[1:0]];
            end
            default: ;
        endcase
    end

    assign w_last = r_half && (r_idx == w_last_idx);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_byte      = r_byte;
        n_col       = r_col;
        n_row       = r_row;
        n_idx       = r_idx;
        n_half      = r_half;
        n_strobe    = 1'b0;
        n_res       = r_res;
        w_bcd_start = 1'b0;
        w_bcd_next  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_op   = i_item.cmd;
                n_byte = i_item.byte_value;
                n_col  = i_item.column;
                n_row  = i_item.row;
                n_idx  = '0;
                n_half = 1'b0;
                if (w_accept) begin
                    unique case (i_item.cmd)
                        CMD_BYTE, CMD_CHAR, CMD_CURSOR, CMD_CLEAR, CMD_INIT:
                            n_state = S_BYTES;
                        CMD_NUMBER: begin
                            n_state     = S_DIGITS;
                            w_bcd_start = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_BYTES: begin
                n_strobe              = 1'b1;
                n_res.register_select = w_rs;
                n_res.nibble          = r_half ? w_cur[3:0] : w_cur[7:4];
                n_res.last_of_run     = w_last;
                n_half                = !r_half;
                if (r_half) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DIGITS: begin
                if (w_bcd.ready) begin
                    n_strobe              = 1'b1;
                    n_res.register_select = 1'b1;
                    n_res.nibble          = r_half ? w_bcd.digit : DIGIT_BASE[7:4];
                    n_res.last_of_run     = r_half && w_bcd.last;
                    n_half                = !r_half;
                    w_bcd_next            = r_half;
                    if (r_half && w_bcd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_op   <= n_op;
        r_byte <= n_byte;
        r_col  <= n_col;
        r_row  <= n_row;
        r_idx  <= n_idx;
        r_half <= n_half;
        r_res  <= n_res;
    end

    lcdnw_bcd #(
        .CONV_BITS (CONV_BITS),
        .NDIG      (NDIG)
    ) u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_bcd_start),
        .i_value  (i_item.number[CONV_BITS-1:0]),
        .i_next   (w_bcd_next),
        .o_status (w_bcd)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `ASSERT_IMPLIES(a_last_frees, i_clk, i_rst_n, o_strobe && o_result.last_of_run, !busy)
    `ASSERT_IMPLIES(a_next_ready, i_clk, i_rst_n, w_bcd_next, w_bcd.ready)
    `ASSERT_IMPLIES(a_idle_conv, i_clk, i_rst_n, !busy, !w_bcd.ready)
    `ASSERT_IMPLIES(a_first_out, i_clk, i_rst_n, w_accept && (i_item.cmd == CMD_BYTE), ##2 o_strobe)

endmodule

// ===== rtl/lcdnw_bcd.sv =====
// ---------------------------------------------------------------------------
// LCD writer decimal converter
// Bit-serial binary to BCD conversion, leading zero skip and digit shift-out.
// ---------------------------------------------------------------------------
module lcdnw_bcd #(
    parameter int CONV_BITS = 32,
    parameter int NDIG      = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CONV_BITS-1:0]   i_value,
    input  logic                   i_next,
    output lcdnw_pkg::t_bcd_status o_status
);
    import lcdnw_pkg::*;

    localparam int CW = $clog2(CONV_BITS + 1);
    localparam int LW = $clog2(NDIG + 1);
    localparam int BW = NDIG * 4;

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_DABBLE = 2'd1;
    localparam logic [1:0] B_SKIP   = 2'd2;
    localparam logic [1:0] B_READY  = 2'd3;

    logic [1:0]           r_bst, n_bst;
    logic [CONV_BITS-1:0] r_bin, n_bin;
    logic [BW-1:0]        r_bcd, n_bcd;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [LW-1:0]        r_left, n_left;
    logic [BW-1:0]        w_adj;
    logic [3:0]           w_top;

    assign w_top = r_bcd[BW-1 -: 4];

    // Add three to every digit of five or more before each shift.
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        n_bst  = r_bst;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_left = r_left;
        unique case (r_bst)
            B_IDLE: begin
                if (i_start) begin
                    n_bst  = B_DABBLE;
                    n_bin  = i_value;
                    n_bcd  = '0;
                    n_cnt  = CW'(CONV_BITS);
                    n_left = LW'(NDIG);
                end
            end
            B_DABBLE: begin
                n_bcd = {w_adj[BW-2:0], r_bin[CONV_BITS-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_bst = B_SKIP;
                end
            end
            B_SKIP: begin
                // The lowest digit is always kept, so zero prints one digit.
                if (w_top == 4'd0 && r_left > LW'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                end else begin
                    n_bst = B_READY;
                end
            end
            B_READY: begin
                if (i_next) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_bst = B_IDLE;
                    end
                end
            end
            default: n_bst = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst <= B_IDLE;
        end else begin
            r_bst <= n_bst;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
    end

    assign o_status.ready = (r_bst == B_READY);
    assign o_status.last  = (r_left == LW'(1));
    assign o_status.digit = w_top;

endmodule
